// File: sv/deq_pkg.sv
package deq_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 64;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam int OP_W     = 3;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_REVERSE    = 3'd4,
		OP_PEEK_FRONT = 3'd5,
		OP_PEEK_BACK  = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic commit;
	} deq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} deq_stat_t;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	function automatic idx_t idx_next(input idx_t i);
		idx_t r;
		if (i == idx_t'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = i + idx_t'(1);
		end
		return r;
	endfunction

	function automatic idx_t idx_prev(input idx_t i);
		idx_t r;
		if (i == '0) begin
			r = idx_t'(CAPACITY - 1);
		end else begin
			r = i - idx_t'(1);
		end
		return r;
	endfunction

endpackage

// File: sv/deq_req_if.sv
interface deq_req_if;
	logic                       valid;
	logic                       ready;
	logic [deq_pkg::OP_W-1:0]   operation;
	logic [deq_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output operation, output push_value, input ready);
	modport sink (input valid, input operation, input push_value, output ready);
endinterface

// File: sv/deq_rsp_if.sv
interface deq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [deq_pkg::DATA_W-1:0]   read_value;
	logic [deq_pkg::STATUS_W-1:0] status;
	logic [deq_pkg::COUNT_W-1:0]  entry_count;
	logic                         empty_flag;

	modport source (output valid, output read_value, output status, output entry_count,
		output empty_flag, input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		input empty_flag, output ready);
endinterface

// File: sv/deq_ctrl.sv
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);
	import deq_pkg::*;

	state_t state_q;
	state_t state_d;

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance: take word, read entry, commit when the output slot is free
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// drive commands
	always_comb begin
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_FINISH: begin
				cmd.commit = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/deq_dpath.sv
module deq_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [deq_pkg::OP_W-1:0]   operation,
	input  logic [deq_pkg::DATA_W-1:0] push_value,
	input  deq_pkg::deq_cmd_t          cmd,
	output deq_pkg::deq_stat_t         stat,
	deq_rsp_if.source                  rsp
);
	import deq_pkg::*;

	logic [VALUE_WIDTH-1:0] mem_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_data_q;

	logic [OP_W-1:0]        op_q;
	logic [VALUE_WIDTH-1:0] val_q;

	idx_t head_q;
	idx_t tail_q;
	cnt_t count_q;
	logic rev_q;

	logic out_valid_q;

	logic    front_op;
	logic    at_head;
	logic    is_empty;
	logic    is_full;
	idx_t    rd_addr;
	idx_t    wr_addr;
	logic    wr_en;
	idx_t    head_d;
	idx_t    tail_d;
	cnt_t    count_d;
	logic    rev_d;
	logic    rd_ok;
	status_t status_d;

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			val_q <= push_value[VALUE_WIDTH-1:0];
		end
	end

	// map logical end to physical end
	always_comb begin
		front_op = (op_q == OP_PUSH_FRONT) || (op_q == OP_POP_FRONT) ||
			(op_q == OP_PEEK_FRONT);
		at_head  = front_op ? !rev_q : rev_q;
		is_empty = (count_q == '0);
		is_full  = (count_q >= cnt_t'(CAPACITY));
		rd_addr  = at_head ? head_q : idx_prev(tail_q);
	end

	// decode operation into next pointers, write and status
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		rev_d    = rev_q;
		wr_en    = 1'b0;
		wr_addr  = at_head ? idx_prev(head_q) : tail_q;
		rd_ok    = 1'b0;
		status_d = ST_OK;
		case (op_q) inside
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + cnt_t'(1);
					if (at_head) begin
						head_d = idx_prev(head_q);
					end else begin
						tail_d = idx_next(tail_q);
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_ok   = 1'b1;
					count_d = count_q - cnt_t'(1);
					if (at_head) begin
						head_d = idx_next(head_q);
					end else begin
						tail_d = idx_prev(tail_q);
					end
				end
			end
			OP_PEEK_FRONT, OP_PEEK_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_ok = 1'b1;
				end
			end
			OP_REVERSE: begin
				rev_d = !rev_q;
			end
			default: begin
			end
		endcase
	end

	// entry store: registered read, write on commit
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (cmd.commit && wr_en) begin
			mem_q[wr_addr] <= val_q;
		end
	end

	// advance pointers on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd.commit) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

	// output register valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp.read_value  <= rd_ok ? DATA_W'(rd_data_q) : '0;
			rsp.status      <= status_d;
			rsp.entry_count <= COUNT_W'(count_d);
			rsp.empty_flag  <= (count_d == '0);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || rsp.ready;

endmodule

// File: sv/double_ended_queue_top.sv
// Sequence: a word is accepted in idle, the entry is read in the next cycle and the result
// loads into the output register in the finish state once the output slot is free.
// A new word is accepted only in idle, after the previous result has committed; a result
// held by rsp backpressure stalls the commit step and with it the next accept.
// Reset: arst_n clears pointers, count, reversal flag, state and output valid at once;
// the entry store is not cleared, since only written entries are ever read.
module double_ended_queue_top (
	input logic       clk,
	input logic       arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (req.operation),
		.push_value (req.push_value),
		.cmd        (cmd),
		.stat       (stat),
		.rsp        (rsp)
	);

endmodule
